[rtl/psc_pkg.sv]
`timescale 1ns / 1ps

package psc_pkg;

  // Internal fixed point: signed, 40 fraction bits
  localparam int CF = 40;

  // Multiplier operands: signed OP_W, magnitude MAG_W split into two halves
  localparam int OP_W   = 49;
  localparam int MAG_W  = 48;
  localparam int HALF_W = 24;
  localparam int PP_W   = 2 * HALF_W;
  localparam int SUM_W  = 2 * MAG_W + 1;
  localparam int RES_W  = SUM_W - CF;

  // Constants rounded to nearest at CF fraction bits
  localparam logic signed [63:0] PI_Q     = 64'sh0000_0324_3F6A_8886;
  localparam logic signed [63:0] TWOPI_Q  = 64'sh0000_0648_7ED5_110B;
  localparam logic signed [63:0] HALFPI_Q = 64'sh0000_0192_1FB5_4443;
  localparam logic signed [63:0] PM_Q     = 64'sh0000_0324_3F69_D860;
  localparam logic signed [63:0] XMAX_Q   = 64'sd8 <<< CF;

  // P(u) = c0 + c1*u + ... + c5*u^5
  localparam logic signed [63:0] COEF [6] = '{
    -64'sd111403815550,
     64'sd7279734326,
    -64'sd190770820,
     64'sd2773289,
    -64'sd25638,
     64'sd146
  };

endpackage

[rtl/psc_front.sv]
`timescale 1ns / 1ps

module psc_front import psc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 27
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic                   op,
  input  logic signed [30:0]     angle,
  input  logic                   skip_wrap,
  output logic                   x_vld,
  output logic signed [OP_W-1:0] x
);

  localparam int SHIFT = CF - ANGLE_FRAC_BITS;
  localparam int X0_W  = 31 + SHIFT + 2;

  localparam logic signed [X0_W-1:0] PI_X     = X0_W'(PI_Q);
  localparam logic signed [X0_W-1:0] NPI_X    = -X0_W'(PI_Q);
  localparam logic signed [X0_W-1:0] TWOPI_X  = X0_W'(TWOPI_Q);
  localparam logic signed [X0_W-1:0] HALFPI_X = X0_W'(HALFPI_Q);
  localparam logic signed [X0_W-1:0] XMAX_X   = X0_W'(XMAX_Q);
  localparam logic signed [X0_W-1:0] NXMAX_X  = -X0_W'(XMAX_Q);

  logic                   v1_r, v2_r, v3_r;
  logic                   skip1_r;
  logic signed [X0_W-1:0] x0_r, x0_nxt;
  logic signed [X0_W-1:0] xw_r, xw_nxt;
  logic signed [OP_W-1:0] x_r, x_nxt;
  logic signed [X0_W-1:0] ax;

  // stage 1: scale to CF fraction bits, cosine adds pi/2
  always_comb begin
    ax     = X0_W'(angle) <<< SHIFT;
    x0_nxt = op ? ax + HALFPI_X : ax;
  end

  // stage 2: one add or subtract of 2*pi toward [-pi, pi]; skip_wrap bypasses it
  always_comb begin
    if (skip1_r) begin
      xw_nxt = x0_r;
    end else if (x0_r > PI_X) begin
      xw_nxt = x0_r - TWOPI_X;
    end else if (x0_r < NPI_X) begin
      xw_nxt = x0_r + TWOPI_X;
    end else begin
      xw_nxt = x0_r;
    end
  end

  // stage 3: clamp to +/-8
  always_comb begin
    if (xw_r > XMAX_X) begin
      x_nxt = OP_W'(XMAX_X);
    end else if (xw_r < NXMAX_X) begin
      x_nxt = OP_W'(NXMAX_X);
    end else begin
      x_nxt = OP_W'(xw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    x0_r    <= x0_nxt;
    skip1_r <= skip_wrap;
    xw_r    <= xw_nxt;
    x_r     <= x_nxt;
  end

  assign x_vld = v3_r;
  assign x     = x_r;

endmodule

[rtl/psc_mulq.sv]
`timescale 1ns / 1ps

// round(a*b / 2^CF) ties away from zero, plus addend; four stages
module psc_mulq import psc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [OP_W-1:0]  a,
  input  logic signed [OP_W-1:0]  b,
  input  logic signed [RES_W-1:0] addend,
  output logic                    out_vld,
  output logic signed [RES_W-1:0] res
);

  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (CF - 1);

  logic                    v1_r, v2_r, v3_r, v4_r;
  logic                    neg1_r, neg2_r, neg3_r;
  logic [MAG_W-1:0]        ma_r, mb_r;
  logic [PP_W-1:0]         ll_r, lh_r, hl_r, hh_r;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic signed [RES_W-1:0] res_r, res_nxt;
  logic signed [OP_W-1:0]  a_abs, b_abs;
  logic [PP_W:0]           mid;
  logic [RES_W-1:0]        mag;

  always_comb begin
    a_abs = a[OP_W-1] ? -a : a;
    b_abs = b[OP_W-1] ? -b : b;
  end

  always_comb begin
    mid     = {1'b0, lh_r} + {1'b0, hl_r};
    sum_nxt = {1'b0, hh_r, ll_r} + (SUM_W'(mid) << HALF_W) + RND;
  end

  always_comb begin
    mag     = {1'b0, sum_r[CF +: RES_W-1]};
    res_nxt = neg3_r ? addend - $signed(mag) : addend + $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= a[OP_W-1] ^ b[OP_W-1];
    ma_r   <= a_abs[MAG_W-1:0];
    mb_r   <= b_abs[MAG_W-1:0];
    neg2_r <= neg1_r;
    ll_r   <= ma_r[HALF_W-1:0] * mb_r[HALF_W-1:0];
    lh_r   <= ma_r[HALF_W-1:0] * mb_r[MAG_W-1:HALF_W];
    hl_r   <= ma_r[MAG_W-1:HALF_W] * mb_r[HALF_W-1:0];
    hh_r   <= ma_r[MAG_W-1:HALF_W] * mb_r[MAG_W-1:HALF_W];
    neg3_r <= neg2_r;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
  end

  assign out_vld = v4_r;
  assign res     = res_r;

endmodule

[rtl/poly_sine_cosine_core.sv]
`timescale 1ns / 1ps

// Sine / cosine by a degree-13 odd polynomial, fully pipelined.
// Throughput: one item per clock; busy is never asserted. Depth: 3 front-end
// stages, eight 4-stage multipliers in series (x^2, five Horner steps, *P, *x)
// and 3 output stages; (x-pm)*(x+pm) runs beside the Horner chain.
// Reset (rst_n low, synchronous) clears all valid bits; datapath regs are not reset.
module poly_sine_cosine_core import psc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 27,
  parameter int OUT_FRAC_BITS   = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [30:0] in_angle,
  input  logic               in_skip_wrap,
  output logic               out_strobe,
  output logic signed [31:0] out_value
);

  localparam int LATENCY = 38;
  localparam int X_DLY   = 28;  // x is reused by the last product
  localparam int X_TAP   = 18;  // feeds (x-pm)*(x+pm), lands next to P
  localparam int X2_DLY  = 16;  // x^2 for Horner steps two to five
  localparam int RS      = CF - OUT_FRAC_BITS;
  localparam int ONE_W   = OUT_FRAC_BITS + 1;
  localparam int MAG_O_W = RES_W - 1;

  localparam logic signed [OP_W-1:0] PM_X    = OP_W'(PM_Q);
  localparam logic [MAG_O_W-1:0]     HALF_O  = MAG_O_W'(1) << (RS - 1);
  // |t| at or above this rounds to more than one
  localparam logic [MAG_O_W-1:0]     LIM_O   = (MAG_O_W'(1) << CF) + (MAG_O_W'(1) << RS)
                                               - (MAG_O_W'(1) << (RS - 1));
  localparam logic signed [31:0]     ONE_S   = 32'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [31:0]     NONE_S  = -(32'sd1 <<< OUT_FRAC_BITS);

  // front end: scale, pi/2 shift, wrap, clamp
  logic                   x_vld;
  logic signed [OP_W-1:0] x;

  psc_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .op       (in_op),
    .angle    (in_angle),
    .skip_wrap(in_skip_wrap),
    .x_vld    (x_vld),
    .x        (x)
  );

  // x delay line, one register per tap
  logic signed [OP_W-1:0] x_dly_r [X_DLY];

  always_ff @(posedge clk) begin
    x_dly_r[0] <= x;
    for (int i = 1; i < X_DLY; i++) begin
      x_dly_r[i] <= x_dly_r[i-1];
    end
  end

  // u = x^2
  logic                    x2_vld;
  logic signed [RES_W-1:0] x2_res;
  logic signed [OP_W-1:0]  x2_dly_r [X2_DLY];

  psc_mulq u_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (x_vld),
    .a      (x),
    .b      (x),
    .addend ('0),
    .out_vld(x2_vld),
    .res    (x2_res)
  );

  always_ff @(posedge clk) begin
    x2_dly_r[0] <= x2_res[OP_W-1:0];
    for (int i = 1; i < X2_DLY; i++) begin
      x2_dly_r[i] <= x2_dly_r[i-1];
    end
  end

  // Horner: p = p*u + c[k], k = 4 down to 0
  logic                    hv [5];
  logic signed [RES_W-1:0] hp [5];

  for (genvar k = 0; k < 5; k++) begin : g_horner
    logic signed [OP_W-1:0] ha, hb;
    logic                   hin;
    if (k == 0) begin : g_first
      assign ha  = OP_W'(COEF[5]);
      assign hb  = x2_res[OP_W-1:0];
      assign hin = x2_vld;
    end else begin : g_next
      assign ha  = hp[k-1][OP_W-1:0];
      assign hb  = x2_dly_r[4*k-1];
      assign hin = hv[k-1];
    end
    psc_mulq u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (hin),
      .a      (ha),
      .b      (hb),
      .addend (RES_W'(COEF[4-k])),
      .out_vld(hv[k]),
      .res    (hp[k])
    );
  end

  // (x - pm) * (x + pm), timed to meet P
  logic signed [OP_W-1:0]  xm_r, xp_r;
  logic                    t1_vld;
  logic signed [RES_W-1:0] t1;

  always_ff @(posedge clk) begin
    xm_r <= x_dly_r[X_TAP] - PM_X;
    xp_r <= x_dly_r[X_TAP] + PM_X;
  end

  psc_mulq u_t1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (hv[3]),
    .a      (xm_r),
    .b      (xp_r),
    .addend ('0),
    .out_vld(t1_vld),
    .res    (t1)
  );

  // t1 * P, then * x
  logic                    t2_vld, t3_vld;
  logic signed [RES_W-1:0] t2, t3;

  psc_mulq u_t2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (hv[4] & t1_vld),
    .a      (t1[OP_W-1:0]),
    .b      (hp[4][OP_W-1:0]),
    .addend ('0),
    .out_vld(t2_vld),
    .res    (t2)
  );

  psc_mulq u_t3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (t2_vld),
    .a      (t2[OP_W-1:0]),
    .b      (x_dly_r[X_DLY-1]),
    .addend ('0),
    .out_vld(t3_vld),
    .res    (t3)
  );

  // output: round to OUT_FRAC_BITS (ties away), clamp to +/-1
  logic                 r1_vld_r, r2_vld_r, r3_vld_r;
  logic                 neg1_r, neg2_r;
  logic [MAG_O_W-1:0]   mag_r;
  logic [ONE_W-1:0]     rnd_r;
  logic                 sat_r;
  logic signed [31:0]   val_r, val_nxt;
  logic signed [RES_W-1:0] t3_abs;
  logic [MAG_O_W:0]     rnd_sum;
  logic [31:0]          vmag;

  always_comb begin
    t3_abs  = t3[RES_W-1] ? -t3 : t3;
    rnd_sum = {1'b0, mag_r} + {1'b0, HALF_O};
  end

  always_comb begin
    vmag    = sat_r ? ONE_S : {{(32-ONE_W){1'b0}}, rnd_r};
    val_nxt = neg2_r ? -$signed(vmag) : $signed(vmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
      r3_vld_r <= 1'b0;
    end else begin
      r1_vld_r <= t3_vld;
      r2_vld_r <= r1_vld_r;
      r3_vld_r <= r2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= t3[RES_W-1];
    mag_r  <= t3_abs[MAG_O_W-1:0];
    neg2_r <= neg1_r;
    rnd_r  <= rnd_sum[RS +: ONE_W];
    sat_r  <= (mag_r >= LIM_O);
    val_r  <= val_nxt;
  end

  assign busy       = 1'b0;
  assign out_strobe = r3_vld_r;
  assign out_value  = val_r;

`ifndef SYNTHESIS
  // the polynomial branch and the (x-pm)(x+pm) branch must stay aligned
  a_branch_align: assert property (@(posedge clk) disable iff (!rst_n)
    hv[4] == t1_vld)
    else $error("P and (x-pm)(x+pm) out of step");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("item did not come out after the pipeline latency");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_value <= ONE_S && out_value >= NONE_S))
    else $error("result beyond +/-1.0");
`endif

endmodule
